FILE: hw/rtl/skhs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skhs_pkg: shared types and constants for the stick to heading/speed block
// Holds the CORDIC arctangent table, angle constants and the stage control
// bundle that travels down the pipeline beside the data.
// ----------------------------------------------------------------------------
package skhs_pkg;

    // Width of every payload port
    localparam int FIELD_W   = 16;
    // Extra fraction bits on each axis during the CORDIC run
    localparam int GUARD     = 8;
    // Number of entries in the arctangent table
    localparam int TABLE_LEN = 24;
    // Angle accumulator width, units of 1/32768 degree
    localparam int Z_W       = 25;
    // Shift from 1/32768 degree down to 1/128 degree
    localparam int HEAD_SHIFT = 8;

    localparam logic signed [Z_W-1:0] DEG90      = 25'sd2949120;
    localparam logic signed [Z_W-1:0] ROUND_BIAS = 25'sd128;
    localparam logic signed [FIELD_W-1:0] HEAD_MAX = 16'sd23040;
    localparam logic signed [FIELD_W-1:0] HEAD_MIN = -16'sd23040;
    localparam logic [FIELD_W-1:0] SPEED_MAX = 16'hFFFF;

    // atan(2^-i) in 1/32768 degree, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
        25'sd117189,  25'sd58652,  25'sd29333,  25'sd14667,
        25'sd7334,    25'sd3667,   25'sd1833,   25'sd917,
        25'sd458,     25'sd229,    25'sd115,    25'sd57,
        25'sd29,      25'sd14,     25'sd7,      25'sd4,
        25'sd2,       25'sd1,      25'sd0,      25'sd0
    };

    // Control bundle carried with every pipeline stage
    typedef struct packed {
        logic valid;  // stage holds a sample
        logic stop;   // stop trigger was set
        logic zero;   // both axes were zero
    } t_ctl;

endpackage
`default_nettype wire

FILE: hw/rtl/stick_to_heading_and_speed.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stick_to_heading_and_speed: joystick sample to wheel heading and speed
// Four-quadrant arctangent by a pipelined vectoring CORDIC, magnitude by a
// pipelined bit-per-stage integer square root, both run side by side.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                      | flow control
//  ----------+--------------------------------------------+-----------------
//  sample in | i_stick_x, i_stick_y, i_stop_level         | i_start / o_busy
//  result    | o_heading_deg, o_wheel_speed               | o_valid strobe
//
//  The pipeline runs through the input register, pre-rotate and squares, sum,
//  one stage per CORDIC step / root bit, and the rounding stage that drives
//  the outputs.
//  A new sample transfers every cycle; o_busy is always low.
//  The stage count is set by the longer of the CORDIC chain and the root chain.
//  Reset (synchronous, active low) clears only the control bits; data follows.
//  Results are shown for one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module stick_to_heading_and_speed
    import skhs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int AXIS_BITS    = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic signed [FIELD_W-1:0] i_stick_x,
    input  wire logic signed [FIELD_W-1:0] i_stick_y,
    input  wire logic [FIELD_W-1:0]        i_stop_level,
    output logic                           o_valid,
    output logic signed [FIELD_W-1:0]      o_heading_deg,
    output logic [FIELD_W-1:0]             o_wheel_speed
);

    localparam int DEPTH = (CORDIC_STEPS > AXIS_BITS) ? CORDIC_STEPS : AXIS_BITS;
    localparam int XW    = AXIS_BITS + GUARD + 3;
    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int HW    = Z_W - HEAD_SHIFT;
    localparam int RW    = (AXIS_BITS + 1 > FIELD_W + 1) ? AXIS_BITS + 1 : FIELD_W + 1;

    // Input register: trim each axis to AXIS_BITS and take it as signed
    t_ctl                        r_ctl0, n_ctl0;
    logic signed [AXIS_BITS-1:0] r_sx, r_sy, w_sx_in, w_sy_in;

    assign w_sx_in = $signed(AXIS_BITS'($unsigned(i_stick_x)));
    assign w_sy_in = $signed(AXIS_BITS'($unsigned(i_stick_y)));

    always_comb begin
        n_ctl0.valid = i_start;
        n_ctl0.stop  = |i_stop_level;
        n_ctl0.zero  = (w_sx_in == '0) && (w_sy_in == '0);
    end

    // Pre-rotate and square stage
    t_ctl                  r_ctl1;
    logic signed [XW-1:0]  r_x1, r_y1, n_x1, n_y1, w_xe, w_ye;
    logic signed [Z_W-1:0] r_z1, n_z1;
    logic signed [SQ_W-1:0] w_sqx, w_sqy;
    logic [SQ_W-1:0]       r_sqx, r_sqy;

    assign w_xe  = XW'(r_sx) <<< GUARD;
    assign w_ye  = XW'(r_sy) <<< GUARD;
    assign w_sqx = SQ_W'(r_sx) * SQ_W'(r_sx);
    assign w_sqy = SQ_W'(r_sy) * SQ_W'(r_sy);

    // Fold the left half-plane into the right one by a quarter turn
    always_comb begin
        n_x1 = w_xe;
        n_y1 = w_ye;
        n_z1 = '0;
        if (w_xe < 0) begin
            if (w_ye >= 0) begin
                n_x1 = w_ye;
                n_y1 = -w_xe;
                n_z1 = DEG90;
            end else begin
                n_x1 = -w_ye;
                n_y1 = w_xe;
                n_z1 = -DEG90;
            end
        end
    end

    // Sum-of-squares stage, seeds the root chain
    t_ctl                  r_ctl2;
    logic signed [XW-1:0]  r_x2, r_y2;
    logic signed [Z_W-1:0] r_z2;
    logic [SQ_W-1:0]       r_sum2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl0 <= n_ctl0;
            r_ctl1 <= r_ctl0;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx   <= w_sx_in;
        r_sy   <= w_sy_in;
        r_x1   <= n_x1;
        r_y1   <= n_y1;
        r_z1   <= n_z1;
        r_sqx  <= $unsigned(w_sqx);
        r_sqy  <= $unsigned(w_sqy);
        r_x2   <= r_x1;
        r_y2   <= r_y1;
        r_z2   <= r_z1;
        r_sum2 <= r_sqx + r_sqy;
    end

    // Stage chain: up to one CORDIC step and one root bit per stage
    t_ctl                  w_ctl  [DEPTH+1];
    logic signed [XW-1:0]  w_x    [DEPTH+1];
    logic signed [XW-1:0]  w_y    [DEPTH+1];
    logic signed [Z_W-1:0] w_z    [DEPTH+1];
    logic [SQ_W-1:0]       w_rem  [DEPTH+1];
    logic [SQ_W-1:0]       w_root [DEPTH+1];

    assign w_ctl[0]  = r_ctl2;
    assign w_x[0]    = r_x2;
    assign w_y[0]    = r_y2;
    assign w_z[0]    = r_z2;
    assign w_rem[0]  = r_sum2;
    assign w_root[0] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        skhs_stage #(
            .AXIS_BITS (AXIS_BITS),
            .STEP      (k),
            .DO_ROT    (k < CORDIC_STEPS),
            .DO_SQRT   (k < AXIS_BITS)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl[k]),
            .i_x    (w_x[k]),
            .i_y    (w_y[k]),
            .i_z    (w_z[k]),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .o_ctl  (w_ctl[k+1]),
            .o_x    (w_x[k+1]),
            .o_y    (w_y[k+1]),
            .o_z    (w_z[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1])
        );
    end

    // Output stage: round the angle, clamp it, round and saturate the root
    logic                       r_valid;
    logic signed [FIELD_W-1:0]  r_heading, n_heading;
    logic [FIELD_W-1:0]         r_speed, n_speed;
    logic signed [Z_W-1:0]      w_zb;
    logic signed [HW-1:0]       w_head;
    logic [RW-1:0]              w_rnd;
    t_ctl                       w_last;

    assign w_last = w_ctl[DEPTH];
    assign w_zb   = w_z[DEPTH] + ROUND_BIAS;
    assign w_head = HW'(w_zb >>> HEAD_SHIFT);
    // Round to nearest: bump when the remainder exceeds the root
    assign w_rnd  = RW'(w_root[DEPTH][AXIS_BITS-1:0])
                  + RW'(w_rem[DEPTH] > w_root[DEPTH]);

    always_comb begin
        if (w_head > HEAD_MAX) begin
            n_heading = HEAD_MAX;
        end else if (w_head < HEAD_MIN) begin
            n_heading = HEAD_MIN;
        end else begin
            n_heading = w_head[FIELD_W-1:0];
        end
        if (w_rnd > RW'(SPEED_MAX)) begin
            n_speed = SPEED_MAX;
        end else begin
            n_speed = w_rnd[FIELD_W-1:0];
        end
        // Zero stick zeroes heading and speed; stop trigger drops the speed
        if (w_last.zero) begin
            n_heading = '0;
            n_speed   = '0;
        end
        if (w_last.stop) begin
            n_speed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heading <= n_heading;
        r_speed   <= n_speed;
    end

    assign o_busy        = 1'b0;
    assign o_valid       = r_valid;
    assign o_heading_deg = r_heading;
    assign o_wheel_speed = r_speed;

endmodule
`default_nettype wire

FILE: hw/rtl/skhs_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skhs_stage: one pipeline stage of the vectoring CORDIC and square root
// Performs one micro-rotation toward the x axis (if DO_ROT) and resolves one
// bit of the integer square root (if DO_SQRT), then registers the results.
// ----------------------------------------------------------------------------
module skhs_stage
    import skhs_pkg::*;
#(
    parameter int AXIS_BITS = 16,
    parameter int STEP      = 0,
    parameter bit DO_ROT    = 1'b1,
    parameter bit DO_SQRT   = 1'b1,
    localparam int XW       = AXIS_BITS + GUARD + 3,
    localparam int SQ_W     = 2 * AXIS_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ctl                   i_ctl,
    input  wire logic signed [XW-1:0]   i_x,
    input  wire logic signed [XW-1:0]   i_y,
    input  wire logic signed [Z_W-1:0]  i_z,
    input  wire logic [SQ_W-1:0]        i_rem,
    input  wire logic [SQ_W-1:0]        i_root,
    output t_ctl                        o_ctl,
    output logic signed [XW-1:0]        o_x,
    output logic signed [XW-1:0]        o_y,
    output logic signed [Z_W-1:0]       o_z,
    output logic [SQ_W-1:0]             o_rem,
    output logic [SQ_W-1:0]             o_root
);

    localparam int BIT_POS = DO_SQRT ? 2 * (AXIS_BITS - 1 - STEP) : 0;
    localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << BIT_POS;

    t_ctl                  r_ctl;
    logic signed [XW-1:0]  r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0] r_z, n_z;
    logic [SQ_W-1:0]       r_rem, r_root, n_rem, n_root;
    logic signed [XW-1:0]  w_xs, w_ys;
    logic [SQ_W:0]         w_trial;

    assign w_xs    = i_x >>> STEP;
    assign w_ys    = i_y >>> STEP;
    assign w_trial = {1'b0, i_root} + {1'b0, SQ_BIT};

    // Rotate toward the positive x axis
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (DO_ROT) begin
            if (i_y >= 0) begin
                n_x = i_x + w_ys;
                n_y = i_y - w_xs;
                n_z = i_z + ATAN_TAB[STEP];
            end else begin
                n_x = i_x - w_ys;
                n_y = i_y + w_xs;
                n_z = i_z - ATAN_TAB[STEP];
            end
        end
    end

    // Resolve one root bit
    always_comb begin
        n_rem  = i_rem;
        n_root = i_root;
        if (DO_SQRT) begin
            if ({1'b0, i_rem} >= w_trial) begin
                n_rem  = i_rem - w_trial[SQ_W-1:0];
                n_root = (i_root >> 1) + SQ_BIT;
            end else begin
                n_root = i_root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
`default_nettype wire

FILE: hw/rtl/skhs_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skhs_check: port-level checks for the stick to heading/speed block
// Watches transfers and results on the top-level ports and is bound there.
// ----------------------------------------------------------------------------
module skhs_check
    import skhs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int AXIS_BITS    = 16
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_start,
    input wire logic                      o_busy,
    input wire logic signed [FIELD_W-1:0] i_stick_x,
    input wire logic signed [FIELD_W-1:0] i_stick_y,
    input wire logic [FIELD_W-1:0]        i_stop_level,
    input wire logic                      o_valid,
    input wire logic signed [FIELD_W-1:0] o_heading_deg,
    input wire logic [FIELD_W-1:0]        o_wheel_speed
);

    localparam int DEPTH = (CORDIC_STEPS > AXIS_BITS) ? CORDIC_STEPS : AXIS_BITS;
    localparam int LAT   = DEPTH + 4;

    // Every transfer is followed by a matching result on o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##LAT o_valid)
        else $error("transfer without matching result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result without matching transfer");

    // Stop trigger holds the speed at zero
    a_stop_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_stop_level, LAT) != '0 |-> o_wheel_speed == '0)
        else $error("speed nonzero while stopped");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading_deg <= HEAD_MAX && o_heading_deg >= HEAD_MIN)
        else $error("heading out of range");

    // Centered stick gives heading and speed of zero
    a_zero_stick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_stick_x, LAT) == '0 && $past(i_stick_y, LAT) == '0
        |-> o_heading_deg == '0 && o_wheel_speed == '0)
        else $error("centered stick gave nonzero result");

endmodule

bind stick_to_heading_and_speed skhs_check #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .AXIS_BITS    (AXIS_BITS)
) u_skhs_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_stick_x    (i_stick_x),
    .i_stick_y    (i_stick_y),
    .i_stop_level (i_stop_level),
    .o_valid      (o_valid),
    .o_heading_deg(o_heading_deg),
    .o_wheel_speed(o_wheel_speed)
);
`default_nettype wire
